### hw/rtl/pvp_pkg.sv
// Package for the position velocity profiler: commands, config indexes, shared types.
// No dependencies.
package pvp_pkg;

    localparam int CMD_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [31:0] CTRL_PERIOD_MS = 32'd20;

    localparam logic [CMD_W-1:0] CMD_PROCESS = 3'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TARGET  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REACH_TOL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TOL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_RNG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd7;

    typedef struct packed {
        logic load;      // capture request fields, compute error
        logic mul;       // multiply max_velocity by error
        logic div_start; // begin ramp division
        logic finish;    // apply state update, load result
    } pvp_cmd_t;

    typedef struct packed {
        logic need_div;  // request is a step that needs the ramp divide
        logic div_done;
    } pvp_stat_t;

endpackage

### hw/rtl/pvp_if.sv
// Valid/ready channel interfaces for the profiler requests, results and config.
// Depends on pvp_pkg.
interface pvp_req_if import pvp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [31:0]       now_ms;
    logic signed [31:0] measured_position;
    logic signed [31:0] new_target;
    modport source (output valid, command, now_ms, measured_position, new_target, input ready);
    modport sink (input valid, command, now_ms, measured_position, new_target, output ready);
endinterface

interface pvp_rsp_if;
    logic              valid;
    logic              ready;
    logic              drive_valid;
    logic signed [31:0] target_out;
    logic [15:0]       output_speed;
    logic [20:0]       motor_speed;
    logic              busy_flag;
    logic              arrived_flag;
    modport source (output valid, drive_valid, target_out, output_speed, motor_speed,
                    busy_flag, arrived_flag, input ready);
    modport sink (input valid, drive_valid, target_out, output_speed, motor_speed,
                  busy_flag, arrived_flag, output ready);
endinterface

interface pvp_cfg_if import pvp_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/position_velocity_profiler_unit.sv
// Top level of the position velocity profiler: joins controller and datapath.
// Depends on pvp_pkg, pvp_if, pvp_ctrl and pvp_datapath.
//
//  channel  modport  carries
//  req      sink     command, now_ms, measured_position, new_target
//  rsp      source   drive_valid, target_out, output_speed, motor_speed, flags
//  cfg      sink     index, data (register write, always ready)
//
// A request passes through load, multiply and finish, and also through the 49-step
// restoring divider when the ramp speed needs it (error between settle band and decel range).
// Reset is asynchronous; config and state return to their reset values at once.
// A result waits in the output register; the next request is taken meanwhile
// and holds in finish until the previous result has been accepted.
module position_velocity_profiler_unit
    import pvp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    pvp_req_if.sink   req,
    pvp_rsp_if.source rsp,
    pvp_cfg_if.sink   cfg
);

    pvp_cmd_t  cmd;
    pvp_stat_t stat;

    assign cfg.ready = 1'b1;

    pvp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pvp_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .in_command   (req.command),
        .in_now       (req.now_ms),
        .in_pos       (req.measured_position),
        .in_target    (req.new_target),
        .cmd          (cmd),
        .stat         (stat),
        .drive_valid  (rsp.drive_valid),
        .target_out   (rsp.target_out),
        .output_speed (rsp.output_speed),
        .motor_speed  (rsp.motor_speed),
        .busy_flag    (rsp.busy_flag),
        .arrived_flag (rsp.arrived_flag)
    );

endmodule

### hw/rtl/pvp_ctrl.sv
// Controller state machine for the profiler: sequences load, multiply, divide, finish.
// Depends on pvp_pkg.
module pvp_ctrl
    import pvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  pvp_stat_t stat,
    output pvp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DSTA = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // A new request may enter while the result waits; it then holds in finish until the result is taken.
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = stat.need_div ? S_DSTA : S_FIN;
            end
            S_DSTA:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // hold until the previous result has left
                if (!out_valid_next)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/pvp_datapath.sv
// Datapath for the profiler: config registers, state, error, ramp multiply and
// restoring divider, slew limit and arrival logic. Depends on pvp_pkg.
module pvp_datapath
    import pvp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CMD_W-1:0]      in_command,
    input  logic [31:0]           in_now,
    input  logic [31:0]           in_pos,
    input  logic [31:0]           in_target,
    input  pvp_cmd_t              cmd,
    output pvp_stat_t             stat,
    output logic                  drive_valid,
    output logic [31:0]           target_out,
    output logic [15:0]           output_speed,
    output logic [20:0]           motor_speed,
    output logic                  busy_flag,
    output logic                  arrived_flag
);

    // configuration
    logic [15:0] max_vel_reg, min_vel_reg, accel_reg, decel_reg, hold_reg;
    logic [19:0] reach_reg, settle_reg, drange_reg;

    // block state
    logic        enabled_reg, busy_reg, arrived_reg;
    logic [31:0] last_step_reg, band_entry_reg, target_reg;
    logic [15:0] speed_reg;

    // request capture
    logic [CMD_W-1:0] op_reg;
    logic [31:0]      now_reg, tgt_in_reg;
    logic [32:0]      err_reg;
    logic             step_reg;

    // ramp
    logic [48:0] prod_reg;
    logic [48:0] quo_reg;
    logic [20:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        div_busy_reg;

    // output register
    logic        drive_reg, busy_o_reg, arr_o_reg;
    logic [31:0] tout_reg;
    logic [15:0] spd_o_reg;
    logic [20:0] mot_reg;

    logic signed [32:0] diff;
    logic [32:0]        err_abs;
    logic               step_ok;
    logic [31:0]        in_target_sel;

    assign in_target_sel = target_reg;

    assign diff    = $signed({in_target_sel[31], in_target_sel}) - $signed({in_pos[31], in_pos});
    assign err_abs = diff[32] ? 33'(-diff) : 33'(diff);
    assign step_ok = enabled_reg && ((in_now - last_step_reg) >= CTRL_PERIOD_MS);

    assign stat.need_div = step_reg && (err_reg > {13'd0, settle_reg})
                           && (err_reg < {13'd0, drange_reg});
    assign stat.div_done = !div_busy_reg;

    // restoring divide step, one quotient bit per cycle while the divider is busy
    logic [20:0] rem_sh;
    logic [21:0] rem_try;
    assign rem_sh  = {rem_reg[19:0], quo_reg[48]};
    assign rem_try = {1'b0, rem_sh} - {2'b00, drange_reg};

    // target speed
    logic [15:0] tgt_spd;
    always_comb
    begin
        if (err_reg <= {13'd0, settle_reg})
        begin
            tgt_spd = 16'd0;
        end
        else if (err_reg >= {13'd0, drange_reg})
        begin
            tgt_spd = max_vel_reg;
        end
        else if (quo_reg < {33'd0, min_vel_reg})
        begin
            tgt_spd = min_vel_reg;
        end
        else if (quo_reg > {33'd0, max_vel_reg})
        begin
            tgt_spd = max_vel_reg;
        end
        else
        begin
            tgt_spd = quo_reg[15:0];
        end
    end

    // slew limit
    logic [16:0] up_sum;
    logic [16:0] dn_gap;
    logic [15:0] new_speed;
    assign up_sum = {1'b0, speed_reg} + {1'b0, accel_reg};
    assign dn_gap = {1'b0, speed_reg} - {1'b0, tgt_spd};
    always_comb
    begin
        if (speed_reg < tgt_spd)
        begin
            new_speed = ({1'b0, tgt_spd} > up_sum) ? up_sum[15:0] : tgt_spd;
        end
        else
        begin
            new_speed = (dn_gap > {1'b0, decel_reg}) ? (speed_reg - decel_reg) : tgt_spd;
        end
    end

    logic in_band;
    logic hold_met;
    assign in_band  = err_reg <= {13'd0, reach_reg};
    assign hold_met = (now_reg - band_entry_reg) >= {16'd0, hold_reg};

    // next state on finish
    logic        en_n, busy_n, arr_n, drive_n;
    logic [31:0] last_n, band_n, tgtr_n;
    logic [15:0] spd_n;
    always_comb
    begin
        en_n    = enabled_reg;
        busy_n  = busy_reg;
        arr_n   = arrived_reg;
        last_n  = last_step_reg;
        band_n  = band_entry_reg;
        tgtr_n  = target_reg;
        spd_n   = speed_reg;
        drive_n = 1'b0;
        case (op_reg)
            CMD_PROCESS, CMD_QUERY:
            begin
                if (step_reg || (op_reg == CMD_QUERY && enabled_reg))
                begin
                    if (step_reg)
                    begin
                        drive_n = 1'b1;
                        last_n  = now_reg;
                        spd_n   = new_speed;
                    end
                    if (in_band)
                    begin
                        if (hold_met)
                        begin
                            busy_n = 1'b0;
                            arr_n  = 1'b1;
                        end
                    end
                    else
                    begin
                        busy_n = 1'b1;
                        arr_n  = 1'b0;
                        band_n = now_reg;
                    end
                end
            end
            CMD_TARGET:
            begin
                tgtr_n = tgt_in_reg;
                busy_n = 1'b1;
                arr_n  = 1'b0;
                band_n = now_reg;
            end
            CMD_START:
            begin
                en_n   = 1'b1;
                busy_n = 1'b1;
                arr_n  = 1'b0;
                band_n = now_reg;
            end
            CMD_STOP:
            begin
                en_n   = 1'b0;
                busy_n = 1'b0;
                arr_n  = 1'b1;
                spd_n  = 16'd0;
            end
            default:
            begin
                en_n = enabled_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_vel_reg    <= 16'd45875;
            reach_reg      <= 20'd1229;
            settle_reg     <= 20'd51;
            drange_reg     <= 20'd12288;
            min_vel_reg    <= 16'd11796;
            accel_reg      <= 16'd3277;
            decel_reg      <= 16'd3277;
            hold_reg       <= 16'd80;
            enabled_reg    <= 1'b0;
            busy_reg       <= 1'b0;
            arrived_reg    <= 1'b1;
            last_step_reg  <= 32'd0;
            band_entry_reg <= 32'd0;
            target_reg     <= 32'd0;
            speed_reg      <= 16'd0;
            div_busy_reg   <= 1'b0;
            cnt_reg        <= 6'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_VEL:    max_vel_reg <= cfg_data[15:0];
                    REG_REACH_TOL:  reach_reg   <= cfg_data[19:0];
                    REG_SETTLE_TOL: settle_reg  <= cfg_data[19:0];
                    REG_DECEL_RNG:  drange_reg  <= cfg_data[19:0];
                    REG_MIN_VEL:    min_vel_reg <= cfg_data[15:0];
                    REG_ACCEL:      accel_reg   <= cfg_data[15:0];
                    REG_DECEL:      decel_reg   <= cfg_data[15:0];
                    REG_HOLD:       hold_reg    <= cfg_data[15:0];
                    default:        hold_reg    <= hold_reg;
                endcase
            end
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                cnt_reg      <= 6'd0;
            end
            else if (div_busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd48)
                begin
                    div_busy_reg <= 1'b0;
                end
            end
            if (cmd.finish)
            begin
                enabled_reg    <= en_n;
                busy_reg       <= busy_n;
                arrived_reg    <= arr_n;
                last_step_reg  <= last_n;
                band_entry_reg <= band_n;
                target_reg     <= tgtr_n;
                speed_reg      <= spd_n;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_command;
            now_reg    <= in_now;
            tgt_in_reg <= in_target;
            err_reg    <= err_abs;
            step_reg   <= (in_command == CMD_PROCESS) && step_ok;
        end
        if (cmd.mul)
        begin
            // error below decel_range fits 20 bits when the divide is used
            prod_reg <= 49'(max_vel_reg * err_reg[19:0]);
        end
        if (cmd.div_start)
        begin
            quo_reg <= prod_reg;
            rem_reg <= 21'd0;
        end
        else if (div_busy_reg)
        begin
            if (!rem_try[21])
            begin
                rem_reg <= rem_try[20:0];
                quo_reg <= {quo_reg[47:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[47:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            drive_reg  <= drive_n;
            tout_reg   <= tgtr_n;
            spd_o_reg  <= spd_n;
            mot_reg    <= 21'(({5'd0, spd_n} << 5) - ({5'd0, spd_n} << 1));
            busy_o_reg <= en_n && busy_n;
            arr_o_reg  <= arr_n;
        end
    end

    assign drive_valid  = drive_reg;
    assign target_out   = tout_reg;
    assign output_speed = spd_o_reg;
    assign motor_speed  = mot_reg;
    assign busy_flag    = busy_o_reg;
    assign arrived_flag = arr_o_reg;

endmodule

### verif/pvp_tb_if.sv
// Testbench copy point for the profiler channel interfaces.
// The interfaces themselves come from hw/rtl/pvp_if.sv; this file only groups shared tb types.
// Depends on pvp_pkg.
package pvp_tb_pkg;
    import pvp_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [31:0]      now_ms;
        logic [31:0]      measured_position;
        logic [31:0]      new_target;
    } profile_req_t;

    typedef struct packed {
        logic        drive_valid;
        logic [31:0] target_out;
        logic [15:0] output_speed;
        logic [20:0] motor_speed;
        logic        busy_flag;
        logic        arrived_flag;
    } profile_rsp_t;
endpackage

### verif/tb_position_velocity_profiler_unit.sv
// Testbench for position_velocity_profiler_unit: directed and random command streams,
// predicted in-line and checked field by field. Depends on pvp_pkg, pvp_if, pvp_tb_pkg.
module tb_position_velocity_profiler_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import pvp_pkg::*;
    import pvp_tb_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pvp_req_if req ();
    pvp_rsp_if rsp ();
    pvp_cfg_if cfg ();

    position_velocity_profiler_unit dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source),
        .cfg  (cfg.sink)
    );

    always #10 clk = ~clk;

    // configuration and state mirror
    logic [15:0] max_vel, min_vel, acc_step, dec_step, hold_ms;
    logic [19:0] arrive_band, settle_tol, decel_rng;
    logic        en_q, busy_q, arr_q;
    logic [31:0] last_step_q, band_entry_q, target_q;
    logic [15:0] speed_q;

    profile_req_t pending_reqs[$];
    profile_rsp_t expected_rsps[$];
    logic [CFG_IDX_W-1:0] cfg_idx_q[$];
    logic [31:0]          cfg_data_q[$];

    bit failed = 1'b0;
    bit quiet = 1'b0;
    bit req_acc = 1'b0;
    int idle_req = 0;
    int idle_rsp = 0;
    int stall_cycles = 0;

    task automatic mirror_reset();
        max_vel = 16'd45875; arrive_band = 20'd1229; settle_tol = 20'd51;
        decel_rng = 20'd12288; min_vel = 16'd11796; acc_step = 16'd3277;
        dec_step = 16'd3277; hold_ms = 16'd80;
        en_q = 1'b0; busy_q = 1'b0; arr_q = 1'b1;
        last_step_q = '0; band_entry_q = '0; target_q = '0; speed_q = '0;
    endtask

    task automatic mirror_config(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        case (idx)
            REG_MAX_VEL:    max_vel = val[15:0];
            REG_REACH_TOL:  arrive_band = val[19:0];
            REG_SETTLE_TOL: settle_tol = val[19:0];
            REG_DECEL_RNG:  decel_rng = val[19:0];
            REG_MIN_VEL:    min_vel = val[15:0];
            REG_ACCEL:      acc_step = val[15:0];
            REG_DECEL:      dec_step = val[15:0];
            REG_HOLD:       hold_ms = val[15:0];
            default: ;
        endcase
    endtask

    function automatic longint abs_gap(input logic [31:0] pos);
        longint d;
        d = longint'($signed(target_q)) - longint'($signed(pos));
        return d < 0 ? -d : d;
    endfunction

    function automatic void track_arrival(input logic [31:0] now, input logic [31:0] pos);
        logic [31:0] elapsed;
        if (abs_gap(pos) <= longint'(arrive_band))
        begin
            elapsed = now - band_entry_q;
            if (elapsed >= {16'd0, hold_ms})
            begin
                busy_q = 1'b0;
                arr_q = 1'b1;
            end
        end
        else
        begin
            busy_q = 1'b1;
            arr_q = 1'b0;
            band_entry_q = now;
        end
    endfunction

    function automatic profile_rsp_t profile_command(input profile_req_t r);
        profile_rsp_t o;
        logic [31:0] elapsed;
        longint err, ramp, goal, cur;
        o = '0;
        case (r.command)
            CMD_PROCESS:
            begin
                elapsed = r.now_ms - last_step_q;
                if (en_q && elapsed >= CTRL_PERIOD_MS)
                begin
                    last_step_q = r.now_ms;
                    err = abs_gap(r.measured_position);
                    if (err <= longint'(settle_tol)) goal = 0;
                    else if (err >= longint'(decel_rng)) goal = max_vel;
                    else
                    begin
                        ramp = (longint'(max_vel) * err) / longint'(decel_rng);
                        if (ramp < min_vel) goal = min_vel;
                        else if (ramp > max_vel) goal = max_vel;
                        else goal = ramp;
                    end
                    cur = speed_q;
                    if (cur < goal)
                        speed_q = (goal - cur > acc_step) ? 16'(cur + acc_step) : 16'(goal);
                    else
                        speed_q = (goal - cur < -longint'(dec_step)) ?
                                  16'(cur - dec_step) : 16'(goal);
                    track_arrival(r.now_ms, r.measured_position);
                    o.drive_valid = 1'b1;
                end
            end
            CMD_QUERY:
                if (en_q) track_arrival(r.now_ms, r.measured_position);
            CMD_TARGET:
            begin
                target_q = r.new_target;
                busy_q = 1'b1; arr_q = 1'b0; band_entry_q = r.now_ms;
            end
            CMD_START:
            begin
                en_q = 1'b1; busy_q = 1'b1; arr_q = 1'b0; band_entry_q = r.now_ms;
            end
            CMD_STOP:
            begin
                en_q = 1'b0; busy_q = 1'b0; arr_q = 1'b1; speed_q = '0;
            end
            default: ;
        endcase
        o.target_out = target_q;
        o.output_speed = speed_q;
        o.motor_speed = 21'(speed_q * 30);
        o.busy_flag = en_q & busy_q;
        o.arrived_flag = arr_q;
        return o;
    endfunction

    // driver: requests, config writes and result ready
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0; req.command <= '0; req.now_ms <= '0;
            req.measured_position <= '0; req.new_target <= '0;
            cfg.valid <= 1'b0; cfg.index <= '0; cfg.data <= '0;
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready && cfg_idx_q.size() > 0)
            begin
                mirror_config(cfg_idx_q[0], cfg_data_q[0]);
                void'(cfg_idx_q.pop_front());
                void'(cfg_data_q.pop_front());
            end
            if (cfg_idx_q.size() > 0)
            begin
                cfg.valid <= 1'b1; cfg.index <= cfg_idx_q[0]; cfg.data <= cfg_data_q[0];
            end
            else
                cfg.valid <= 1'b0;

            // advance only once the held request was taken at the last rising edge
            if (!req.valid || req_acc)
            begin
                if (idle_req > 0) idle_req--;
                else if (!quiet && $urandom_range(0, 15) == 0)
                    idle_req = $urandom_range(1, 11);
                if (pending_reqs.size() > 0 && idle_req == 0)
                begin
                    req.valid <= 1'b1;
                    req.command <= pending_reqs[0].command;
                    req.now_ms <= pending_reqs[0].now_ms;
                    req.measured_position <= pending_reqs[0].measured_position;
                    req.new_target <= pending_reqs[0].new_target;
                end
                else
                    req.valid <= 1'b0;
            end

            if (idle_rsp > 0)
            begin
                idle_rsp--;
                rsp.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                idle_rsp = $urandom_range(1, 11);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // request acceptance: predict on the edge where it is taken
    always @(posedge clk)
    begin
        req_acc = rst_n && req.valid && req.ready;
        if (req_acc)
        begin
            expected_rsps.push_back(profile_command(pending_reqs[0]));
            void'(pending_reqs.pop_front());
        end
    end

    // monitor
    always @(posedge clk)
    begin
        profile_rsp_t exp_r;
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected result");
                    failed = 1'b1;
                end
                else
                begin
                    exp_r = expected_rsps.pop_front();
                    if (rsp.drive_valid !== exp_r.drive_valid)
                    begin
                        $error("drive_valid exp %0d got %0d", exp_r.drive_valid, rsp.drive_valid);
                        failed = 1'b1;
                    end
                    if (rsp.target_out !== exp_r.target_out)
                    begin
                        $error("target_out exp %0d got %0d",
                               $signed(exp_r.target_out), rsp.target_out);
                        failed = 1'b1;
                    end
                    if (rsp.output_speed !== exp_r.output_speed)
                    begin
                        $error("output_speed exp %0d got %0d",
                               exp_r.output_speed, rsp.output_speed);
                        failed = 1'b1;
                    end
                    if (rsp.motor_speed !== exp_r.motor_speed)
                    begin
                        $error("motor_speed exp %0d got %0d", exp_r.motor_speed, rsp.motor_speed);
                        failed = 1'b1;
                    end
                    if (rsp.busy_flag !== exp_r.busy_flag)
                    begin
                        $error("busy_flag exp %0d got %0d", exp_r.busy_flag, rsp.busy_flag);
                        failed = 1'b1;
                    end
                    if (rsp.arrived_flag !== exp_r.arrived_flag)
                    begin
                        $error("arrived_flag exp %0d got %0d",
                               exp_r.arrived_flag, rsp.arrived_flag);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    logic [31:0] clock_ms = '0;

    task automatic push_cmd(input logic [CMD_W-1:0] c, input logic [31:0] pos,
                            input logic [31:0] tgt);
        profile_req_t r;
        r.command = c; r.now_ms = clock_ms;
        r.measured_position = pos; r.new_target = tgt;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        int settle;
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
        for (settle = 0; settle < 80; settle++) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_idx_q.push_back(idx);
        cfg_data_q.push_back(val);
        while (cfg_idx_q.size() > 0) @(posedge clk);
    endtask

    // one random move: target, start, steps with position closing in, queries and other commands, sometimes a stop
    task automatic random_move(input int steps);
        logic [31:0] goal, pos;
        int k;
        longint gap;
        goal = $urandom();
        if ($urandom_range(0, 3) != 0) goal = 32'($signed(16'($urandom())));
        pos = goal + 32'($signed(20'($urandom())));
        push_cmd(CMD_TARGET, pos, goal);
        push_cmd(CMD_START, pos, '0);
        for (k = 0; k < steps; k++)
        begin
            clock_ms += ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : 32'd20;
            gap = longint'($signed(goal)) - longint'($signed(pos));
            pos = 32'(longint'($signed(pos)) + gap / 3 + $signed($urandom_range(0, 64)) - 32);
            if ($urandom_range(0, 9) == 0) pos = $urandom();
            push_cmd($urandom_range(0, 7) == 0 ? CMD_QUERY :
                     ($urandom_range(0, 30) == 0 ? CMD_TARGET :
                     ($urandom_range(0, 40) == 0 ? 3'($urandom_range(5, 7)) : CMD_PROCESS)),
                     pos, $urandom());
        end
        if ($urandom_range(0, 2) == 0) push_cmd(CMD_STOP, pos, '0);
    endtask

    initial
    begin
        int n, phase;
        mirror_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset settings
        push_cmd(CMD_PROCESS, 32'h0, 32'h0);
        push_cmd(CMD_QUERY, 32'h7FFF_FFFF, 32'h0);
        push_cmd(CMD_TARGET, 32'h0, 32'h7FFF_FFFF);
        push_cmd(CMD_START, 32'h8000_0000, 32'h0);
        clock_ms = 32'd20;
        push_cmd(CMD_PROCESS, 32'h8000_0000, 32'h0);
        clock_ms = 32'd30;
        push_cmd(CMD_PROCESS, 32'h8000_0000, 32'h0);
        push_cmd(CMD_TARGET, 32'h0, 32'h0000_1000);
        clock_ms = 32'd40;
        push_cmd(CMD_PROCESS, 32'h0000_0100, 32'h0);
        clock_ms = 32'd60;
        push_cmd(CMD_PROCESS, 32'h0000_1010, 32'h0);
        clock_ms = 32'd80;
        push_cmd(CMD_PROCESS, 32'h0000_1000, 32'h0);
        clock_ms = 32'd200;
        push_cmd(CMD_QUERY, 32'h0000_1000, 32'h0);
        push_cmd(3'd5, 32'h0, 32'h0);
        push_cmd(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        clock_ms = 32'hFFFF_FFF0;
        push_cmd(CMD_PROCESS, 32'h0, 32'h0);
        clock_ms = 32'd8;
        push_cmd(CMD_PROCESS, 32'h0, 32'h0);
        push_cmd(CMD_STOP, 32'h0, 32'h0);
        push_cmd(CMD_QUERY, 32'h0, 32'h0);
        drain();

        // several settings, extremes among them; each followed by random moves
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin
                    write_reg(REG_MAX_VEL, 32'hFFFF);   write_reg(REG_MIN_VEL, 32'h0);
                    write_reg(REG_ACCEL, 32'hFFFF);     write_reg(REG_DECEL, 32'hFFFF);
                    write_reg(REG_DECEL_RNG, 32'hFFFFF); write_reg(REG_SETTLE_TOL, 32'h0);
                    write_reg(REG_REACH_TOL, 32'h0);    write_reg(REG_HOLD, 32'h0);
                end
                1: begin
                    write_reg(REG_MAX_VEL, 32'd100);    write_reg(REG_MIN_VEL, 32'hFFFF);
                    write_reg(REG_ACCEL, 32'd0);        write_reg(REG_DECEL, 32'd1);
                    write_reg(REG_DECEL_RNG, 32'd1);    write_reg(REG_SETTLE_TOL, 32'hFFFFF);
                    write_reg(REG_REACH_TOL, 32'hFFFFF); write_reg(REG_HOLD, 32'hFFFF);
                end
                2: begin
                    write_reg(REG_DECEL_RNG, 32'd0);    write_reg(REG_SETTLE_TOL, 32'd40);
                    write_reg(REG_ACCEL, 32'd5000);     write_reg(REG_MAX_VEL, 32'd0);
                end
                default: begin
                    write_reg(REG_MAX_VEL, $urandom());
                    write_reg(REG_MIN_VEL, $urandom_range(0, 20000));
                    write_reg(REG_ACCEL, $urandom_range(0, 8000));
                    write_reg(REG_DECEL, $urandom_range(0, 8000));
                    write_reg(REG_DECEL_RNG, $urandom_range(1, 200000));
                    write_reg(REG_SETTLE_TOL, $urandom_range(0, 300));
                    write_reg(REG_REACH_TOL, $urandom_range(0, 5000));
                    write_reg(REG_HOLD, $urandom_range(0, 200));
                end
            endcase
            n = 0;
            while (n < 200)
            begin
                random_move(20);
                n += 23;
            end
            if (phase == 5) quiet = 1'b1;
            drain();
        end

        if (!failed)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### files.f
hw/rtl/pvp_pkg.sv
hw/rtl/pvp_if.sv
hw/rtl/pvp_ctrl.sv
hw/rtl/pvp_datapath.sv
hw/rtl/position_velocity_profiler_unit.sv
verif/pvp_tb_if.sv
verif/tb_position_velocity_profiler_unit.sv
